// File: sv/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// shared types, constants and the arctangent table of the euler angle unit
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int VW        = 40;
    localparam int AW        = 34;
    localparam int TABLE_LEN = 30;
    localparam int RAD_W     = 61;
    localparam int ROOT_W    = 62;
    localparam int SQRT_LEN  = 31;

    localparam logic [1:0] LOCK_NONE = 2'd0;
    localparam logic [1:0] LOCK_POS  = 2'd1;
    localparam logic [1:0] LOCK_NEG  = 2'd2;

    localparam logic signed [34:0]   LOCK_LIMIT = 35'sd536763538;
    localparam logic signed [VW-1:0] ONE_Q30    = 40'sd1073741824;
    localparam logic signed [AW-1:0] NINETY_DEG = 34'sd1509949440;

    localparam logic signed [AW-1:0] ATAN_DEG24 [TABLE_LEN] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489089, 34'sd119537938,
        34'sd60000934, 34'sd30029717, 34'sd15018523, 34'sd7509720,
        34'sd3754917, 34'sd1877466, 34'sd938734, 34'sd469367,
        34'sd234684, 34'sd117342, 34'sd58671, 34'sd29335,
        34'sd14668, 34'sd7334, 34'sd3667, 34'sd1833,
        34'sd917, 34'sd458, 34'sd229, 34'sd115,
        34'sd57, 34'sd29, 34'sd14, 34'sd7,
        34'sd4, 34'sd2
    };

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } vec_t;

endpackage

// File: sv/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// one digit of a pipelined integer square root
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [qte_pkg::RAD_W-1:0]   rem_in,
    input  logic [qte_pkg::ROOT_W-1:0]  root_in,
    output logic [qte_pkg::RAD_W-1:0]   rem_out,
    output logic [qte_pkg::ROOT_W-1:0]  root_out
);
    import qte_pkg::*;

    localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * K);

    logic [RAD_W-1:0]  rem_reg;
    logic [RAD_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [ROOT_W-1:0] trial;
    logic              fits;

    always_comb
    begin
        trial = root_in + BIT;
        fits  = {1'b0, rem_in} >= trial;
        if (fits)
        begin
            rem_next  = rem_in - trial[RAD_W-1:0];
            root_next = (root_in >> 1) + BIT;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// File: sv/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// one vectoring cordic iteration with its angle accumulator
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
    parameter int I = 0
) (
    input  logic          clk,
    input  logic          en,
    input  qte_pkg::vec_t vin,
    output qte_pkg::vec_t vout
);
    import qte_pkg::*;

    vec_t                 v_reg;
    vec_t                 v_next;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;

    always_comb
    begin
        dx     = vin.y >>> I;
        dy     = vin.x >>> I;
        v_next = vin;
        if (vin.y > 0)
        begin
            v_next.x   = vin.x + dx;
            v_next.y   = vin.y - dy;
            v_next.ang = vin.ang + ATAN_DEG24[I];
        end
        else
        begin
            v_next.x   = vin.x - dx;
            v_next.y   = vin.y + dy;
            v_next.ang = vin.ang - ATAN_DEG24[I];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
        end
    end

    assign vout = v_reg;

endmodule

// File: sv/quaternion_to_euler_degrees_unit.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_unit
// quaternion in q2.30 to three euler angles in 1/64 degree
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready with quat_w..quat_z, one quaternion per
// transfer; output channel: out_valid/out_ready with angle_x, angle_y,
// angle_z and lock_case, one result per input transfer, in order
// from input transfer to out_valid the data passes these registers in order
// (multiply, sum, square, subtract, 31 square root digits, quadrant turn,
// one cordic cell per step, output register)
// throughput: one quaternion every cycle; the whole pipeline moves as one
// when the output register is empty or being taken
// when the receiver stalls the output register holds, the whole pipeline
// freezes, bubbles included, and in_ready stays low until the result
// is taken
// reset clears all valid bits; the pipeline comes up empty
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] quat_w,
    input  logic signed [31:0] quat_x,
    input  logic signed [31:0] quat_y,
    input  logic signed [31:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] angle_x,
    output logic signed [13:0] angle_y,
    output logic signed [14:0] angle_z,
    output logic [1:0]         lock_case
);
    import qte_pkg::*;

    localparam int NSTEP    = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SIDE_LEN = SQRT_LEN + 3;
    localparam int LAT      = 4 + SQRT_LEN + 1 + NSTEP;

    typedef struct packed {
        logic [1:0]           lock;
        logic signed [30:0]   s;
        logic signed [VW-1:0] axx;
        logic signed [VW-1:0] axy;
        logic signed [VW-1:0] azx;
        logic signed [VW-1:0] azy;
    } side_t;

    logic en;
    logic valid_reg [LAT];
    logic out_valid_reg;

    // multiply stage
    logic signed [63:0] m_xz, m_wy, m_yy, m_zz, m_ww, m_xw, m_yz, m_xy, m_zw;
    logic signed [33:0] p_xz_reg, p_wy_reg, p_yy_reg, p_zz_reg, p_ww_reg;
    logic signed [33:0] p_xw_reg, p_yz_reg, p_xy_reg, p_zw_reg;
    logic signed [31:0] y_reg, w_reg;

    // sum stage
    logic signed [34:0]   test;
    logic signed [35:0]   s_full;
    logic [1:0]           lock_next;
    logic [29:0]          mag_next;
    logic [29:0]          mag_reg;
    logic signed [VW-1:0] sum_a, sum_b, sum_c, sum_d;
    side_t                side_next;
    side_t                side_reg [SIDE_LEN];

    // square and radicand
    logic [59:0]        sq_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [RAD_W-1:0]   rem_w  [SQRT_LEN+1];
    logic [ROOT_W-1:0]  root_w [SQRT_LEN+1];

    // cordic
    vec_t       pr_next [3];
    vec_t       lane_v  [3][NSTEP+1];
    logic [1:0] lock_reg [NSTEP+1];

    // output
    logic signed [15:0] ax_next, angle_x_reg;
    logic signed [13:0] ay_next, angle_y_reg;
    logic signed [14:0] az_next, angle_z_reg;
    logic [1:0]         lock_case_reg;

    function automatic vec_t prerot(input logic signed [VW-1:0] x,
                                    input logic signed [VW-1:0] y);
        vec_t v;
        v.zero = (x == '0) && (y == '0);
        v.x    = x;
        v.y    = y;
        v.ang  = '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                v.x   = y;
                v.y   = -x;
                v.ang = NINETY_DEG;
            end
            else
            begin
                v.x   = -y;
                v.y   = x;
                v.ang = -NINETY_DEG;
            end
        end
        return v;
    endfunction

    function automatic logic signed [17:0] to_64th(input vec_t v,
                                                   input logic [1:0] lock,
                                                   input logic signed [17:0] lim);
        logic signed [AW:0]   base;
        logic signed [AW+1:0] a;
        logic signed [AW+1:0] r;
        base = v.zero ? '0 : (AW+1)'(v.ang);
        if (lock == LOCK_POS)
        begin
            a = (AW+2)'(base) + (AW+2)'(base);
        end
        else if (lock == LOCK_NEG)
        begin
            a = -((AW+2)'(base) + (AW+2)'(base));
        end
        else
        begin
            a = (AW+2)'(base);
        end
        r = (a + (AW+2)'(1 << 17)) >>> 18;
        if (r > (AW+2)'(lim))
        begin
            r = (AW+2)'(lim);
        end
        if (r < -(AW+2)'(lim))
        begin
            r = -(AW+2)'(lim);
        end
        return r[17:0];
    endfunction

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            out_valid_reg <= valid_reg[LAT-1];
        end
    end

    always_comb
    begin
        m_xz = quat_x * quat_z;
        m_wy = quat_w * quat_y;
        m_yy = quat_y * quat_y;
        m_zz = quat_z * quat_z;
        m_ww = quat_w * quat_w;
        m_xw = quat_x * quat_w;
        m_yz = quat_y * quat_z;
        m_xy = quat_x * quat_y;
        m_zw = quat_z * quat_w;
    end

    always_comb
    begin
        test   = 35'(p_xz_reg) - 35'(p_wy_reg);
        s_full = {test, 1'b0};
        if (test >= LOCK_LIMIT)
        begin
            lock_next = LOCK_POS;
        end
        else if (test <= -LOCK_LIMIT)
        begin
            lock_next = LOCK_NEG;
        end
        else
        begin
            lock_next = LOCK_NONE;
        end
        if (lock_next != LOCK_NONE)
        begin
            mag_next = '0;
        end
        else if (s_full < 0)
        begin
            mag_next = 30'(-s_full);
        end
        else
        begin
            mag_next = s_full[29:0];
        end
        sum_a = VW'(p_xw_reg) + VW'(p_yz_reg);
        sum_b = VW'(p_zz_reg) + VW'(p_ww_reg);
        sum_c = VW'(p_xy_reg) - VW'(p_zw_reg);
        sum_d = VW'(p_yy_reg) + VW'(p_zz_reg);
        side_next.lock = lock_next;
        side_next.s    = s_full[30:0];
        if (lock_next != LOCK_NONE)
        begin
            side_next.axx = VW'(w_reg);
            side_next.axy = VW'(y_reg);
        end
        else
        begin
            side_next.axx = ONE_Q30 - (sum_b <<< 1);
            side_next.axy = sum_a <<< 1;
        end
        side_next.azx = ONE_Q30 - (sum_d <<< 1);
        side_next.azy = sum_c <<< 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_xz_reg <= m_xz[63:30];
            p_wy_reg <= m_wy[63:30];
            p_yy_reg <= m_yy[63:30];
            p_zz_reg <= m_zz[63:30];
            p_ww_reg <= m_ww[63:30];
            p_xw_reg <= m_xw[63:30];
            p_yz_reg <= m_yz[63:30];
            p_xy_reg <= m_xy[63:30];
            p_zw_reg <= m_zw[63:30];
            y_reg    <= quat_y;
            w_reg    <= quat_w;
            mag_reg  <= mag_next;
            side_reg[0] <= side_next;
            for (int k = 1; k < SIDE_LEN; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            sq_reg  <= 60'(mag_reg) * 60'(mag_reg);
            rad_reg <= (RAD_W'(1) << 60) - RAD_W'(sq_reg);
        end
    end

    assign rem_w[0]  = rad_reg;
    assign root_w[0] = '0;

    genvar j, l, st;
    generate
        for (j = 0; j < SQRT_LEN; j++)
        begin : g_sqrt
            qte_sqrt_cell #(
                .K(SQRT_LEN - 1 - j)
            ) u_cell (
                .clk      (clk),
                .en       (en),
                .rem_in   (rem_w[j]),
                .root_in  (root_w[j]),
                .rem_out  (rem_w[j+1]),
                .root_out (root_w[j+1])
            );
        end
    endgenerate

    always_comb
    begin
        pr_next[0] = prerot(side_reg[SIDE_LEN-1].axx, side_reg[SIDE_LEN-1].axy);
        pr_next[1] = prerot(VW'(root_w[SQRT_LEN][30:0]), VW'(side_reg[SIDE_LEN-1].s));
        pr_next[2] = prerot(side_reg[SIDE_LEN-1].azx, side_reg[SIDE_LEN-1].azy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lock_reg[0] <= side_reg[SIDE_LEN-1].lock;
            for (int n = 1; n <= NSTEP; n++)
            begin
                lock_reg[n] <= lock_reg[n-1];
            end
        end
    end

    generate
        for (l = 0; l < 3; l++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lane_v[l][0] <= pr_next[l];
                end
            end
            for (st = 0; st < NSTEP; st++)
            begin : g_step
                qte_cordic_cell #(
                    .I(st)
                ) u_cell (
                    .clk  (clk),
                    .en   (en),
                    .vin  (lane_v[l][st]),
                    .vout (lane_v[l][st+1])
                );
            end
        end
    endgenerate

    always_comb
    begin
        ax_next = 16'(to_64th(lane_v[0][NSTEP], lock_reg[NSTEP], 18'sd23040));
        if (lock_reg[NSTEP] == LOCK_POS)
        begin
            ay_next = 14'sd5760;
            az_next = '0;
        end
        else if (lock_reg[NSTEP] == LOCK_NEG)
        begin
            ay_next = -14'sd5760;
            az_next = '0;
        end
        else
        begin
            ay_next = 14'(to_64th(lane_v[1][NSTEP], LOCK_NONE, 18'sd5760));
            az_next = 15'(to_64th(lane_v[2][NSTEP], LOCK_NONE, 18'sd11520));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_x_reg   <= ax_next;
            angle_y_reg   <= ay_next;
            angle_z_reg   <= az_next;
            lock_case_reg <= lock_reg[NSTEP];
        end
    end

    assign out_valid = out_valid_reg;
    assign angle_x   = angle_x_reg;
    assign angle_y   = angle_y_reg;
    assign angle_z   = angle_z_reg;
    assign lock_case = lock_case_reg;

endmodule
